// File: sv/crc16_byte_stuffing_framer_macros.svh
// Assertion macros shared by the framer modules.
// Each macro takes a label, the clock, the active-low reset and the property terms.
`ifndef CRC16_BYTE_STUFFING_FRAMER_MACROS_SVH
`define CRC16_BYTE_STUFFING_FRAMER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define CRCF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define CRCF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CRCF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CRCF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/crcf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package crcf_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_START  = 2'd0;
    localparam logic [1:0] CFG_STOP   = 2'd1;
    localparam logic [1:0] CFG_ESCAPE = 2'd2;

    // Reset values of the flag registers.
    localparam logic [7:0] START_RESET  = 8'd126;
    localparam logic [7:0] STOP_RESET   = 8'd127;
    localparam logic [7:0] ESCAPE_RESET = 8'd125;

    // Substitute codes that follow the escape byte.
    localparam logic [7:0] SUB_START  = 8'hDC;
    localparam logic [7:0] SUB_STOP   = 8'hDD;
    localparam logic [7:0] SUB_ESCAPE = 8'hDE;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // One payload byte as it travels from the front to the back.
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        first;
        logic [15:0] crc;
    } t_job;

    // Current flag values.
    typedef struct packed {
        logic [7:0] start;
        logic [7:0] stop;
        logic [7:0] escape;
    } t_flags;

    // CRC-16 update with one byte, MSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] c);
        logic [15:0] crc;
        crc = crc_in ^ {c, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage
`default_nettype wire

// File: sv/crcf_front.sv
`timescale 1ns / 1ps
`default_nettype none
`include "crc16_byte_stuffing_framer_macros.svh"
module crcf_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_last_byte,
    input  wire logic          i_full,
    output logic               o_push,
    output crcf_pkg::t_job     o_job
);
    import crcf_pkg::*;

    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic        r_in_frame;
    logic        n_in_frame;
    logic [15:0] w_crc_upd;

    // Accept whenever the queue has room.
    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;
    assign w_crc_upd  = crc_byte(r_crc, i_data_byte);

    // Classify the byte and attach the updated CRC.
    always_comb begin
        o_job.data  = i_data_byte;
        o_job.last  = i_last_byte;
        o_job.first = !r_in_frame;
        o_job.crc   = w_crc_upd;
    end

    // Frame state: the CRC restarts and the frame closes after the last byte.
    always_comb begin
        n_crc      = r_crc;
        n_in_frame = r_in_frame;
        if (o_push) begin
            n_crc      = i_last_byte ? CRC_INIT : w_crc_upd;
            n_in_frame = !i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc      <= CRC_INIT;
            r_in_frame <= 1'b0;
        end else begin
            r_crc      <= n_crc;
            r_in_frame <= n_in_frame;
        end
    end

    `CRCF_ASSERT_NXT(a_close_frame, i_clk, i_rst_n, o_push && i_last_byte, !r_in_frame && (r_crc == CRC_INIT))

endmodule
`default_nettype wire

// File: sv/crcf_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module crcf_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire crcf_pkg::t_job i_job,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output crcf_pkg::t_job     o_job
);
    import crcf_pkg::*;

    t_job       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rd];

    // Occupancy follows push and pop.
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule
`default_nettype wire

// File: sv/crcf_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "crc16_byte_stuffing_framer_macros.svh"
module crcf_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire crcf_pkg::t_flags i_flags,
    input  wire logic          i_job_valid,
    input  wire crcf_pkg::t_job i_job,
    output logic               o_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [7:0]         o_out_byte,
    output logic               o_last_out
);
    import crcf_pkg::*;

    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_DATA  = 3'd1;
    localparam logic [2:0] PH_CRCLO = 3'd2;
    localparam logic [2:0] PH_CRCHI = 3'd3;
    localparam logic [2:0] PH_STOP  = 3'd4;

    logic [2:0] r_phase;
    logic [2:0] n_phase;
    logic       r_esc_pending;
    logic       n_esc_pending;
    logic       r_out_valid;
    logic       n_out_valid;
    logic [7:0] r_out_byte;
    logic [7:0] n_out_byte;
    logic       r_last_out;
    logic       n_last_out;

    logic [2:0] w_phase;
    logic [7:0] w_value;
    logic [7:0] w_sub;
    logic       w_hit;
    logic       w_adv;
    logic       w_done;

    // A byte goes out whenever a job waits and the output register is free.
    assign w_adv = i_job_valid && (!r_out_valid || i_out_ready);
    assign o_pop = w_adv && w_done;

    // A job that continues a frame skips the start flag.
    assign w_phase = (r_phase == PH_START && !i_job.first) ? PH_DATA : r_phase;

    // Byte to be stuffed in the current phase.
    always_comb begin
        case (w_phase)
            PH_CRCLO: w_value = i_job.crc[7:0];
            PH_CRCHI: w_value = i_job.crc[15:8];
            default:  w_value = i_job.data;
        endcase
    end

    // Flag match: escape wins over end, end over start.
    always_comb begin
        w_hit = 1'b1;
        w_sub = SUB_ESCAPE;
        if (w_value == i_flags.escape) begin
            w_sub = SUB_ESCAPE;
        end else if (w_value == i_flags.stop) begin
            w_sub = SUB_STOP;
        end else if (w_value == i_flags.start) begin
            w_sub = SUB_START;
        end else begin
            w_hit = 1'b0;
        end
    end

    // Emission sequencer.
    always_comb begin
        n_phase       = r_phase;
        n_esc_pending = r_esc_pending;
        n_out_byte    = r_out_byte;
        w_done        = 1'b0;
        case (w_phase)
            PH_START: begin
                n_out_byte = i_flags.start;
                n_phase    = PH_DATA;
            end
            PH_DATA, PH_CRCLO, PH_CRCHI: begin
                if (r_esc_pending) begin
                    n_out_byte    = w_sub;
                    n_esc_pending = 1'b0;
                end else if (w_hit) begin
                    n_out_byte    = i_flags.escape;
                    n_esc_pending = 1'b1;
                    n_phase       = w_phase;
                end else begin
                    n_out_byte = w_value;
                end
                if (r_esc_pending || !w_hit) begin
                    case (w_phase)
                        PH_DATA: begin
                            if (i_job.last) begin
                                n_phase = PH_CRCLO;
                            end else begin
                                n_phase = PH_START;
                                w_done  = 1'b1;
                            end
                        end
                        PH_CRCLO: n_phase = PH_CRCHI;
                        default:  n_phase = PH_STOP;
                    endcase
                end
            end
            PH_STOP: begin
                n_out_byte = i_flags.stop;
                n_phase    = PH_START;
                w_done     = 1'b1;
            end
            default: begin
                n_phase = PH_START;
            end
        endcase
        n_last_out = w_done;
    end

    // Output register valid.
    always_comb begin
        if (w_adv) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_START;
            r_esc_pending <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_adv) begin
                r_phase       <= n_phase;
                r_esc_pending <= n_esc_pending;
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_byte <= n_out_byte;
            r_last_out <= n_last_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last_out  = r_last_out;

    `CRCF_ASSERT_IMP(a_esc_phase, i_clk, i_rst_n, r_esc_pending, (r_phase == PH_DATA) || (r_phase == PH_CRCLO) || (r_phase == PH_CRCHI))
    `CRCF_ASSERT_IMP(a_esc_held, i_clk, i_rst_n, r_esc_pending, r_out_valid && !r_last_out && i_job_valid)
    `CRCF_ASSERT_IMP(a_esc_byte, i_clk, i_rst_n, $rose(r_esc_pending), r_out_byte == i_flags.escape)

endmodule
`default_nettype wire

// File: sv/crc16_byte_stuffing_framer.sv
`timescale 1ns / 1ps
`default_nettype none
// Transmit framer with CRC-16 and byte stuffing.
// Input channel (i_in_valid / o_in_ready) carries one payload byte and a last flag per
// transaction. Output channel (o_out_valid / i_out_ready) carries one framed byte per
// transaction; o_last_out marks the final byte caused by one input byte.
// Configuration channel (i_cfg_valid / o_cfg_ready) writes the start, end and escape flag
// values at index 0, 1 and 2; other indexes are ignored. It is always ready.
// The front computes the CRC and frame position in the accept cycle and places the byte
// in a two-entry queue. The back emits one output byte per cycle from the queue head while
// the receiver takes each byte. With the queue empty, the first output byte of an item
// passes the queue entry and then the output byte register before it is presented.
// An item causes one output byte for a plain mid-frame byte, two for an escaped byte and
// up to eight for a one-byte frame; the back sends them one after another through the
// single output byte register and pops the item when it loads the item's final byte.
// Reset: flags return to 126, 127 and 125, the CRC to 0xFFFF, no frame is open and the
// queue and output register are empty.
// When the receiver stalls, the output byte holds, the back stops and the queue fills;
// the input channel drops ready once both queue entries are taken.
module crc16_byte_stuffing_framer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_last_out,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);
    import crcf_pkg::*;

    t_flags r_flags;
    t_job   w_push_job;
    t_job   w_head_job;
    logic   w_push;
    logic   w_full;
    logic   w_head_valid;
    logic   w_pop;

    assign o_cfg_ready = 1'b1;

    // Flag registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags.start  <= START_RESET;
            r_flags.stop   <= STOP_RESET;
            r_flags.escape <= ESCAPE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_START:  r_flags.start  <= i_cfg_data;
                CFG_STOP:   r_flags.stop   <= i_cfg_data;
                CFG_ESCAPE: r_flags.escape <= i_cfg_data;
                default:    r_flags        <= r_flags;
            endcase
        end
    end

    crcf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_job       (w_push_job)
    );

    crcf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_job   (w_head_job)
    );

    crcf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_flags     (r_flags),
        .i_job_valid (w_head_valid),
        .i_job       (w_head_job),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_last_out  (o_last_out)
    );

endmodule
`default_nettype wire
